// File: rtl/core/grhc_pkg.sv
// Shared types and constants for the guest register host cache.
package grhc_pkg;

   localparam int unsigned CACHE_SLOTS = 3;
   // Each register holds its slot number plus one; zero means no slot.
   localparam int unsigned SLOT_W      = $clog2(CACHE_SLOTS + 1);
   localparam int unsigned NUM_DWORDS  = 8;
   localparam int unsigned CSLOT_W     = 2;

   localparam logic [3:0] SHIFT_HIGH_BYTE = 4'd8;
   localparam logic [3:0] SHIFT_NONE      = 4'd0;

   typedef enum logic [1:0] {
      OP_LOAD      = 2'd0,
      OP_STORE_REG = 2'd1,
      OP_STORE_IMM = 2'd2,
      OP_FORGET    = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ACT_MEM_LOAD  = 3'd0,
      ACT_FILL_COPY = 3'd1,
      ACT_COPY      = 3'd2,
      ACT_STORE     = 3'd3,
      ACT_STORE_UPD = 3'd4,
      ACT_STORE_INV = 3'd5,
      ACT_FORGOTTEN = 3'd6
   } action_type;

   localparam logic [2:0] WIDTH_BYTE = 3'd1;
   localparam logic [2:0] WIDTH_WORD = 3'd2;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [2:0]  guest_reg;
      logic [2:0]  width_bytes;
      logic [3:0]  host_operand;
      logic [31:0] immediate;
      logic [31:0] jump_epoch;
   } req_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [1:0]  cache_slot;
      logic [2:0]  dword_index;
      logic [3:0]  byte_shift;
      logic        mask_low;
      logic [3:0]  host_operand_out;
      logic [31:0] immediate_out;
   } rsp_type;

endpackage

// File: rtl/core/grhc_if.sv
// Valid/ready channel interfaces for access requests and decisions.
interface grhc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [2:0]  guest_reg;
   logic [2:0]  width_bytes;
   logic [3:0]  host_operand;
   logic [31:0] immediate;
   logic [31:0] jump_epoch;

   modport source (output valid, opcode, guest_reg, width_bytes, host_operand, immediate,
                   jump_epoch, input ready);
   modport sink (input valid, opcode, guest_reg, width_bytes, host_operand, immediate,
                 jump_epoch, output ready);
endinterface

interface grhc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [1:0]  cache_slot;
   logic [2:0]  dword_index;
   logic [3:0]  byte_shift;
   logic        mask_low;
   logic [3:0]  host_operand_out;
   logic [31:0] immediate_out;

   modport source (output valid, action, cache_slot, dword_index, byte_shift, mask_low,
                   host_operand_out, immediate_out, input ready);
   modport sink (input valid, action, cache_slot, dword_index, byte_shift, mask_low,
                 host_operand_out, immediate_out, output ready);
endinterface

// File: rtl/core/guest_register_host_cache.sv
// Top level: input register, decision logic and result register.
//
//   channel | modport | role
//   --------+---------+------------------------------------------
//   req_chan| sink    | guest register access items in
//   rsp_chan| source  | one decision item per access out
//
// One item per cycle sustained while rsp_chan is not stalled; a taken item moves from the
// input register to the result register, which drives rsp_chan. The slot table and live
// mask are read and written in the cycle that moves an item from input to result register.
// Synchronous active-high reset empties both registers and clears all cache state.
// A stall on rsp_chan holds the result register; the input register then fills and
// req_chan.ready drops until the result is taken.
module guest_register_host_cache (
   input logic        clock,
   input logic        reset,
   grhc_req_if.sink   req_chan,
   grhc_rsp_if.source rsp_chan
);

   logic              in_valid_ff;
   grhc_pkg::req_type in_data_ff;
   logic              out_valid_ff;
   grhc_pkg::rsp_type out_data_ff;
   grhc_pkg::rsp_type out_data_in;
   logic              advance;
   logic              take;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;

   grhc_state u_state (
      .clock  (clock),
      .reset  (reset),
      .commit (advance),
      .req    (in_data_ff),
      .rsp    (out_data_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (take) begin
         in_data_ff.opcode       <= req_chan.opcode;
         in_data_ff.guest_reg    <= req_chan.guest_reg;
         in_data_ff.width_bytes  <= req_chan.width_bytes;
         in_data_ff.host_operand <= req_chan.host_operand;
         in_data_ff.immediate    <= req_chan.immediate;
         in_data_ff.jump_epoch   <= req_chan.jump_epoch;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_chan.valid            = out_valid_ff;
   assign rsp_chan.action           = out_data_ff.action;
   assign rsp_chan.cache_slot       = out_data_ff.cache_slot;
   assign rsp_chan.dword_index      = out_data_ff.dword_index;
   assign rsp_chan.byte_shift       = out_data_ff.byte_shift;
   assign rsp_chan.mask_low         = out_data_ff.mask_low;
   assign rsp_chan.host_operand_out = out_data_ff.host_operand_out;
   assign rsp_chan.immediate_out    = out_data_ff.immediate_out;

   a_advance_needs_item: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("result register empty after a move");

   a_no_drop_on_stall: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_chan.ready |=> out_valid_ff && $stable(out_data_ff))
      else $error("stalled result lost");

   a_full_blocks_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && !rsp_chan.ready |-> !req_chan.ready)
      else $error("input taken with both registers held");

endmodule

// File: rtl/core/grhc_state.sv
// Slot table, live mask and epoch state with the per-access decision logic.
module grhc_state (
   input  logic              clock,
   input  logic              reset,
   input  logic              commit,
   input  grhc_pkg::req_type req,
   output grhc_pkg::rsp_type rsp
);

   logic [grhc_pkg::SLOT_W-1:0]     slot_of_reg_ff [grhc_pkg::NUM_DWORDS];
   logic [grhc_pkg::SLOT_W-1:0]     slots_used_ff;
   logic [grhc_pkg::NUM_DWORDS-1:0] live_ff;
   logic [31:0]                     epoch_ff;

   logic [grhc_pkg::NUM_DWORDS-1:0] live_base;
   logic [grhc_pkg::NUM_DWORDS-1:0] live_in;
   logic                            claim;
   grhc_pkg::opcode_type            op;
   logic                            is_byte;
   logic                            full;
   logic                            high_byte;
   logic [2:0]                      dword;
   logic                            has_slot;
   logic                            can_claim;
   logic                            cached;
   logic [grhc_pkg::SLOT_W-1:0]     slot_num;
   logic                            live_bit;

   always_comb begin
      op        = grhc_pkg::opcode_type'(req.opcode);
      is_byte   = (req.width_bytes == grhc_pkg::WIDTH_BYTE);
      full      = !(is_byte || (req.width_bytes == grhc_pkg::WIDTH_WORD));
      high_byte = is_byte && req.guest_reg[2];
      dword     = high_byte ? {1'b0, req.guest_reg[1:0]} : req.guest_reg;
      // A new epoch drops every cached copy before this access is looked at.
      live_base = (epoch_ff != req.jump_epoch) ? '0 : live_ff;
      live_bit  = live_base[dword];
      has_slot  = (slot_of_reg_ff[dword] != '0);
      can_claim = full && !has_slot &&
                  (slots_used_ff < grhc_pkg::SLOT_W'(grhc_pkg::CACHE_SLOTS));
      cached    = has_slot || can_claim;
      slot_num  = has_slot ? slot_of_reg_ff[dword] - grhc_pkg::SLOT_W'(1) : slots_used_ff;

      live_in = live_base;
      claim   = 1'b0;
      rsp     = '0;
      rsp.dword_index = dword;

      unique case (op)
         grhc_pkg::OP_FORGET: begin
            live_in         = '0;
            rsp.action      = grhc_pkg::ACT_FORGOTTEN;
            rsp.dword_index = '0;
         end
         grhc_pkg::OP_LOAD: begin
            rsp.host_operand_out = req.host_operand;
            claim = can_claim;
            if (!cached || (!live_bit && !full)) begin
               rsp.action = grhc_pkg::ACT_MEM_LOAD;
            end else begin
               rsp.action     = live_bit ? grhc_pkg::ACT_COPY : grhc_pkg::ACT_FILL_COPY;
               live_in[dword] = 1'b1;
               rsp.cache_slot = grhc_pkg::CSLOT_W'(slot_num);
               rsp.byte_shift = high_byte ? grhc_pkg::SHIFT_HIGH_BYTE : grhc_pkg::SHIFT_NONE;
               rsp.mask_low   = !full;
            end
         end
         grhc_pkg::OP_STORE_REG, grhc_pkg::OP_STORE_IMM: begin
            if (op == grhc_pkg::OP_STORE_REG) begin
               rsp.host_operand_out = req.host_operand;
            end else begin
               rsp.immediate_out = req.immediate;
            end
            claim = can_claim;
            if (!cached) begin
               rsp.action = grhc_pkg::ACT_STORE;
            end else if (full) begin
               rsp.action     = grhc_pkg::ACT_STORE_UPD;
               rsp.cache_slot = grhc_pkg::CSLOT_W'(slot_num);
               live_in[dword] = 1'b1;
            end else begin
               rsp.action     = grhc_pkg::ACT_STORE_INV;
               live_in[dword] = 1'b0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < grhc_pkg::NUM_DWORDS; i++) begin
            slot_of_reg_ff[i] <= '0;
         end
         slots_used_ff <= '0;
         live_ff       <= '0;
         epoch_ff      <= '0;
      end else if (commit) begin
         live_ff  <= live_in;
         epoch_ff <= req.jump_epoch;
         if (claim) begin
            slots_used_ff         <= slots_used_ff + grhc_pkg::SLOT_W'(1);
            slot_of_reg_ff[dword] <= slots_used_ff + grhc_pkg::SLOT_W'(1);
         end
      end
   end

   // Consistency checks across the slot table and the live mask.
   logic live_without_slot;
   logic slot_beyond_used;
   always_comb begin
      live_without_slot = 1'b0;
      slot_beyond_used  = 1'b0;
      for (int i = 0; i < grhc_pkg::NUM_DWORDS; i++) begin
         if (live_ff[i] && (slot_of_reg_ff[i] == '0)) live_without_slot = 1'b1;
         if (slot_of_reg_ff[i] > slots_used_ff) slot_beyond_used = 1'b1;
      end
   end

   a_slots_bounded: assert property (@(posedge clock) disable iff (reset)
      slots_used_ff <= grhc_pkg::SLOT_W'(grhc_pkg::CACHE_SLOTS))
      else $error("slot count past cache size");

   a_live_has_slot: assert property (@(posedge clock) disable iff (reset)
      !live_without_slot)
      else $error("live copy for register without slot");

   a_slot_in_range: assert property (@(posedge clock) disable iff (reset)
      !slot_beyond_used)
      else $error("register owns slot not yet given out");

   a_slots_only_on_commit: assert property (@(posedge clock) disable iff (reset)
      !commit |=> $stable(slots_used_ff) && $stable(live_ff))
      else $error("state changed without an item");

endmodule
